FILE: hw/rtl/jfns_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfns_pkg: shared types and constants for the Jacobi four-neighbour sweep
// Value format, grid limits, register map and the stage-one operand bundle.
// ----------------------------------------------------------------------------
package jfns_pkg;

    localparam int VALUE_BITS      = 24;                  // unsigned Q8.16
    localparam int SUM_BITS        = VALUE_BITS + 2;      // four-term sum
    localparam int MAX_SIDE        = 1024;
    localparam int MIN_SIDE        = 3;
    localparam int COL_BITS        = $clog2(MAX_SIDE);    // row/column index
    localparam int SIDE_BITS       = COL_BITS + 1;        // holds MAX_SIDE itself

    localparam int GRID_SIDE_BITS  = 11;
    localparam int THRESHOLD_BITS  = 24;
    localparam int CFG_DATA_BITS   = 24;
    localparam int CFG_INDEX_BITS  = 1;

    localparam logic [GRID_SIDE_BITS-1:0] GRID_SIDE_RESET = GRID_SIDE_BITS'(10);
    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = THRESHOLD_BITS'(65536);

    // register map
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_SIDE        = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE_THRESHOLD = 1'd1;

    typedef logic [VALUE_BITS-1:0] value_t;

    // one line store word: the column's value two rows up and one row up
    typedef struct packed {
        value_t up;
        value_t mid;
    } line_word_t;

    // stencil operands of one interior cell
    typedef struct packed {
        value_t left;
        value_t right;
        value_t up;
        value_t down;
        value_t old;
        logic   last;
    } stencil_t;

endpackage : jfns_pkg
`default_nettype wire

FILE: hw/rtl/jfns_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfns_line_store: two-row line buffer
// One write and one registered read per cycle; each word packs the
// upper-row and middle-row values of one column.
// ----------------------------------------------------------------------------
module jfns_line_store (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [jfns_pkg::COL_BITS-1:0] wr_addr,
    input  wire jfns_pkg::line_word_t          wr_data,
    input  wire logic                          rd_en,
    input  wire logic [jfns_pkg::COL_BITS-1:0] rd_addr,
    output jfns_pkg::line_word_t               rd_data
);
    import jfns_pkg::*;

    line_word_t mem [MAX_SIDE];
    line_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : jfns_line_store
`default_nettype wire

FILE: hw/rtl/jfns_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfns_scan: raster position, line store and neighbour window
// Tracks row/column, shifts the line store at the current column, reads
// two columns ahead, and registers the stencil operands of interior cells.
// ----------------------------------------------------------------------------
module jfns_scan (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           restart,
    input  wire logic                           accept,
    input  wire jfns_pkg::value_t               cell_value,
    input  wire logic [jfns_pkg::SIDE_BITS-1:0] side,
    input  wire logic                           advance,
    output logic                                s1_valid,
    output jfns_pkg::stencil_t                  s1
);
    import jfns_pkg::*;

    logic [COL_BITS-1:0]  row_reg, row_next;
    logic [COL_BITS-1:0]  col_reg, col_next;
    logic                 s1_valid_reg, s1_valid_next;
    stencil_t             s1_reg, s1_next;
    line_word_t           cur_reg;       // old word of the current column
    value_t               left_reg;      // old middle value of previous column
    line_word_t           rd_data;
    line_word_t           wr_data;
    logic [SIDE_BITS-1:0] side_m1, side_m2;
    logic [SIDE_BITS-1:0] ahead, ahead_wrap;
    logic [COL_BITS-1:0]  rd_addr;
    logic                 row_end, interior;

    assign side_m1 = side - SIDE_BITS'(1);
    assign side_m2 = side - SIDE_BITS'(2);

    // read column c+2, wrapping into the next row (side >= 3 keeps it off c)
    assign ahead      = {1'b0, col_reg} + SIDE_BITS'(2);
    assign ahead_wrap = (ahead >= side) ? (ahead - side) : ahead;
    assign rd_addr    = ahead_wrap[COL_BITS-1:0];

    assign wr_data.up  = cur_reg.mid;
    assign wr_data.mid = cell_value;

    jfns_line_store u_line_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign row_end  = ({1'b0, col_reg} == side_m1);
    assign interior = (row_reg >= COL_BITS'(2)) && (col_reg != '0)
                      && ({1'b0, col_reg} < side_m1);

    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (advance) begin
            s1_valid_next = 1'b0;
        end
        if (accept) begin
            s1_valid_next = interior;
            s1_next.left  = left_reg;
            s1_next.right = rd_data.mid;
            s1_next.up    = cur_reg.up;
            s1_next.down  = cell_value;
            s1_next.old   = cur_reg.mid;
            s1_next.last  = ({1'b0, row_reg} == side_m1) && ({1'b0, col_reg} == side_m2);
            if (row_end) begin
                col_next = '0;
                row_next = ({1'b0, row_reg} == side_m1) ? '0 : row_reg + COL_BITS'(1);
            end else begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
        if (restart) begin
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
        if (accept) begin
            cur_reg  <= rd_data;
            left_reg <= cur_reg.mid;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule : jfns_scan
`default_nettype wire

FILE: hw/rtl/jfns_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfns_stencil: average, movement test and result register
// Sums the four neighbours, compares the change with the threshold and
// keeps the per-sweep settled flag.
// ----------------------------------------------------------------------------
module jfns_stencil (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                restart,
    input  wire logic [jfns_pkg::THRESHOLD_BITS-1:0] threshold,
    input  wire logic                                s1_valid,
    input  wire jfns_pkg::stencil_t                  s1,
    input  wire logic                                m_ready,
    output logic                                     advance,
    output logic                                     m_valid,
    output jfns_pkg::value_t                         m_new_value,
    output logic                                     m_moved,
    output logic                                     m_sweep_end,
    output logic                                     m_sweep_settled
);
    import jfns_pkg::*;

    logic [SUM_BITS-1:0] sum;
    value_t              avg, diff;
    logic                moved;
    logic                load;
    logic                valid_reg, valid_next;
    logic                none_moved_reg, none_moved_next;
    value_t              value_reg;
    logic                moved_reg, end_reg, settled_reg;

    assign sum   = SUM_BITS'(s1.left) + SUM_BITS'(s1.right)
                 + SUM_BITS'(s1.up)   + SUM_BITS'(s1.down);
    assign avg   = sum[SUM_BITS-1:2];
    assign diff  = (avg >= s1.old) ? (avg - s1.old) : (s1.old - avg);
    assign moved = (THRESHOLD_BITS'(diff) >= threshold);

    assign advance = !valid_reg || m_ready;
    assign load    = s1_valid && advance;

    always_comb begin
        valid_next      = valid_reg;
        none_moved_next = none_moved_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            if (s1.last) begin
                none_moved_next = 1'b1;
            end else if (moved) begin
                none_moved_next = 1'b0;
            end
        end
        if (restart) begin
            none_moved_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            none_moved_reg <= 1'b1;
        end else begin
            valid_reg      <= valid_next;
            none_moved_reg <= none_moved_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg   <= avg;
            moved_reg   <= moved;
            end_reg     <= s1.last;
            settled_reg <= s1.last && none_moved_reg && !moved;
        end
    end

    assign m_valid         = valid_reg;
    assign m_new_value     = value_reg;
    assign m_moved         = moved_reg;
    assign m_sweep_end     = end_reg;
    assign m_sweep_settled = settled_reg;

endmodule : jfns_stencil
`default_nettype wire

FILE: hw/rtl/jacobi_four_neighbour_sweep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_four_neighbour_sweep: streaming Jacobi 5-point relaxation sweep
// Top level: register file, side clamp, flow control and checks.
// ----------------------------------------------------------------------------
// Grid cells enter in row-major order, one transfer per cycle sustained,
// with no stall of its own: every cycle one cell is taken unless the result
// side holds back. A cell's transfer loads the operand register (using the
// line store word prefetched by the previous transfer); the arithmetic on
// them moves into the result register when that is empty or being taken,
// and a cell with a result shows it there. The line store is one
// memory with one write and one registered read per cycle, read two columns
// ahead of the write, so it sets the one-cell-per-cycle figure. Boundary cells
// give no result; the cell below an interior cell produces that cell's result.
// Writing grid_side restarts the sweep at row 0, column 0; values outside
// 3..1024 are clamped. Configure only while the block is idle.
// ----------------------------------------------------------------------------
module jacobi_four_neighbour_sweep (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [jfns_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [jfns_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // cell stream
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [jfns_pkg::VALUE_BITS-1:0]     s_cell_value,
    // result stream
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [jfns_pkg::VALUE_BITS-1:0]          m_new_value,
    output logic                                     m_moved,
    output logic                                     m_sweep_end,
    output logic                                     m_sweep_settled
);
    import jfns_pkg::*;

    logic [GRID_SIDE_BITS-1:0] grid_side_reg, grid_side_next;
    logic [THRESHOLD_BITS-1:0] threshold_reg, threshold_next;
    logic [SIDE_BITS-1:0]      side_eff;
    logic                      restart;
    logic                      accept;
    logic                      advance;
    logic                      s1_valid;
    stencil_t                  s1;

    // register file; a grid_side write also restarts the sweep
    always_comb begin
        grid_side_next = grid_side_reg;
        threshold_next = threshold_reg;
        restart        = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_GRID_SIDE: begin
                    grid_side_next = cfg_data[GRID_SIDE_BITS-1:0];
                    restart        = 1'b1;
                end
                CFG_SETTLE_THRESHOLD: begin
                    threshold_next = cfg_data[THRESHOLD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_side_reg <= GRID_SIDE_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else begin
            grid_side_reg <= grid_side_next;
            threshold_reg <= threshold_next;
        end
    end

    // clamp the side into the supported range
    always_comb begin
        priority if (int'(grid_side_reg) < MIN_SIDE) begin
            side_eff = SIDE_BITS'(MIN_SIDE);
        end else if (int'(grid_side_reg) > MAX_SIDE) begin
            side_eff = SIDE_BITS'(MAX_SIDE);
        end else begin
            side_eff = SIDE_BITS'(grid_side_reg);
        end
    end

    // stage one may refill in the same cycle it hands off to the result reg
    assign s_ready = !s1_valid || advance;
    assign accept  = s_valid && s_ready;

    jfns_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .accept     (accept),
        .cell_value (s_cell_value),
        .side       (side_eff),
        .advance    (advance),
        .s1_valid   (s1_valid),
        .s1         (s1)
    );

    jfns_stencil u_stencil (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .restart         (restart),
        .threshold       (threshold_reg),
        .s1_valid        (s1_valid),
        .s1              (s1),
        .m_ready         (m_ready),
        .advance         (advance),
        .m_valid         (m_valid),
        .m_new_value     (m_new_value),
        .m_moved         (m_moved),
        .m_sweep_end     (m_sweep_end),
        .m_sweep_settled (m_sweep_settled)
    );

    // settled is only reported on the sweep's last result
    a_settled_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sweep_settled |-> m_sweep_end)
        else $error("sweep_settled without sweep_end");

    // a sweep whose last cell moved cannot be settled
    a_moved_not_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_moved |-> !m_sweep_settled)
        else $error("settled reported on a moving cell");

    // input only stalls when the result register is full and held
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with free result register");

    // pending stage-one item is handed off once the result side frees
    a_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid && (!m_valid || m_ready) |=> m_valid)
        else $error("stage-one item not moved to result register");

endmodule : jacobi_four_neighbour_sweep
`default_nettype wire

FILE: tb/tb_jacobi_four_neighbour_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jacobi_four_neighbour_sweep: self-checking bench for the Jacobi sweep
// Streams square grids of many sides and fill patterns through the block.
// A scoreboard relaxes each interior cell from its own copy of the line
// stores and checks new value, movement, sweep-end and settled flags in order.
// ----------------------------------------------------------------------------

// one relaxed interior cell as the result port should show it
typedef struct {
    jfns_pkg::value_t new_value;
    logic             moved;
    logic             sweep_end;
    logic             sweep_settled;
} relaxed_cell_t;

class relaxation_scoreboard;
    int unsigned      side_reg;     // raw 11-bit side register
    jfns_pkg::value_t threshold;
    jfns_pkg::value_t upper_row [jfns_pkg::MAX_SIDE];
    jfns_pkg::value_t middle_row [jfns_pkg::MAX_SIDE];
    jfns_pkg::value_t left_old_mid; // old middle value of the previous column
    int unsigned      row;
    int unsigned      col;
    bit               none_moved;
    relaxed_cell_t    expected_cells [$];
    int unsigned      errors;
    int unsigned      cells_seen;
    int unsigned      results_seen;
    int unsigned      sweep_ends;
    int unsigned      settled_sweeps;

    function new();
        side_reg  = jfns_pkg::GRID_SIDE_RESET;
        threshold = jfns_pkg::THRESHOLD_RESET;
        foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        restart();
        errors         = 0;
        cells_seen     = 0;
        results_seen   = 0;
        sweep_ends     = 0;
        settled_sweeps = 0;
    endfunction

    function void restart();
        row          = 0;
        col          = 0;
        none_moved   = 1'b1;
        left_old_mid = '0;
    endfunction

    function int unsigned clamped_side();
        if (side_reg < jfns_pkg::MIN_SIDE) return jfns_pkg::MIN_SIDE;
        if (side_reg > jfns_pkg::MAX_SIDE) return jfns_pkg::MAX_SIDE;
        return side_reg;
    endfunction

    function int unsigned pending();
        return expected_cells.size();
    endfunction

    function void write_reg(logic [jfns_pkg::CFG_INDEX_BITS-1:0] index,
                            logic [jfns_pkg::CFG_DATA_BITS-1:0]  data);
        if (index == jfns_pkg::CFG_GRID_SIDE) begin
            side_reg = data[jfns_pkg::GRID_SIDE_BITS-1:0];
            restart();
        end else if (index == jfns_pkg::CFG_SETTLE_THRESHOLD) begin
            threshold = data[jfns_pkg::THRESHOLD_BITS-1:0];
        end
    endfunction

    // the incoming cell is the lower neighbour of the cell one row up
    function void note_cell(jfns_pkg::value_t down);
        int unsigned                     side;
        logic [jfns_pkg::SUM_BITS-1:0]   sum;
        jfns_pkg::value_t                relaxed;
        jfns_pkg::value_t                old;
        jfns_pkg::value_t                change;
        relaxed_cell_t                   exp_item;
        side = clamped_side();
        cells_seen++;
        if (row >= side || col >= side) restart();
        if (row >= 2 && col >= 1 && col + 1 < side) begin
            old     = middle_row[col];
            sum     = {2'b00, left_old_mid} + {2'b00, middle_row[col + 1]}
                    + {2'b00, upper_row[col]} + {2'b00, down};
            relaxed = sum[jfns_pkg::SUM_BITS-1:2];
            change  = (relaxed >= old) ? relaxed - old : old - relaxed;
            exp_item.new_value     = relaxed;
            exp_item.moved         = (change >= threshold);
            exp_item.sweep_end     = (row == side - 1) && (col == side - 2);
            exp_item.sweep_settled = 1'b0;
            if (exp_item.moved) none_moved = 1'b0;
            if (exp_item.sweep_end) begin
                exp_item.sweep_settled = none_moved;
                none_moved             = 1'b1;
            end
            expected_cells.push_back(exp_item);
        end
        left_old_mid    = middle_row[col];
        upper_row[col]  = middle_row[col];
        middle_row[col] = down;
        col++;
        if (col >= side) begin
            col = 0;
            row++;
            if (row >= side) row = 0;
        end
    endfunction

    function void check_result(jfns_pkg::value_t new_value, logic moved,
                               logic sweep_end, logic sweep_settled);
        relaxed_cell_t exp_item;
        if (expected_cells.size() == 0) begin
            $error("unexpected result: new_value=%06h moved=%0b end=%0b settled=%0b",
                   new_value, moved, sweep_end, sweep_settled);
            errors++;
            return;
        end
        exp_item = expected_cells.pop_front();
        results_seen++;
        if (exp_item.new_value !== new_value) begin
            $error("new_value: expected %06h, got %06h", exp_item.new_value, new_value);
            errors++;
        end
        if (exp_item.moved !== moved) begin
            $error("moved: expected %0b, got %0b", exp_item.moved, moved);
            errors++;
        end
        if (exp_item.sweep_end !== sweep_end) begin
            $error("sweep_end: expected %0b, got %0b", exp_item.sweep_end, sweep_end);
            errors++;
        end
        if (exp_item.sweep_settled !== sweep_settled) begin
            $error("sweep_settled: expected %0b, got %0b",
                   exp_item.sweep_settled, sweep_settled);
            errors++;
        end
        if (exp_item.sweep_end) sweep_ends++;
        if (exp_item.sweep_settled) settled_sweeps++;
    endfunction
endclass

module tb_jacobi_four_neighbour_sweep;
    import jfns_pkg::*;

    localparam int          CLK_HALF      = 10;     // 20 ns period
    localparam int          RESET_CYCLES  = 11;
    localparam int          IDLE_MAX      = 12;     // per-transfer idle draw
    localparam int          LONG_HOLD     = 300;    // long output stall
    localparam int          SETTLE_CYCLES = 8;      // two-register pipeline plus margin
    localparam int unsigned RANDOM_CELLS  = 1100;
    localparam int unsigned MAX_SIDE_CELLS = 200;   // partial first row at the limit
    localparam value_t      VALUE_MAX     = '1;

    // grid contents used by the random phases
    typedef enum {FILL_RANDOM, FILL_FLAT, FILL_SMOOTH, FILL_EXTREME} fill_t;

    logic                      aclk         = 1'b0;
    logic                      aresetn      = 1'b0;
    logic                      cfg_we       = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    value_t                    s_cell_value = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    value_t                    m_new_value;
    logic                      m_moved;
    logic                      m_sweep_end;
    logic                      m_sweep_settled;

    relaxation_scoreboard sweep_sb;

    // idle limits per side, changed per phase; zero gives back-to-back transfers
    int unsigned tx_gap_max   = IDLE_MAX;
    int unsigned rx_gap_max   = IDLE_MAX;
    bit          hold_request = 1'b0;
    int unsigned cells_sent   = 0;
    int unsigned phases       = 0;

    jacobi_four_neighbour_sweep i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cell_value    (s_cell_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_value     (m_new_value),
        .m_moved         (m_moved),
        .m_sweep_end     (m_sweep_end),
        .m_sweep_settled (m_sweep_settled)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Monitor: register writes, cell transfers and result transfers are all
    // sampled at the edge where they happen. Config and cell traffic never
    // share a cycle, so the order of the calls below does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sweep_sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sweep_sb.note_cell(s_cell_value);
            if (m_valid && m_ready)
                sweep_sb.check_result(m_new_value, m_moved, m_sweep_end, m_sweep_settled);
        end
    end

    // Result side: random stall before each transfer. A hold request from the
    // stimulus turns the next stall into a long one so the line pipeline
    // fills and s_ready has to drop.
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = LONG_HOLD;
            end else begin
                stall = $urandom_range(0, rx_gap_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
        end
    end

    // One cell transfer. Valid stays up across back-to-back cells; it only
    // drops when an idle gap is drawn.
    task automatic send_cell(input value_t value);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cells_sent++;
    endtask

    // Stop offering cells, let every expected result come out, then give
    // cells without results time to finish their line store update.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sweep_sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // single register write; the trailing cycle keeps writes apart
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic value_t fill_value(fill_t fill, value_t base, int unsigned spread);
        case (fill)
            FILL_FLAT:    return base;
            FILL_SMOOTH:  return base + value_t'($urandom_range(0, spread));
            FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? VALUE_MAX : value_t'(0);
            default:      return value_t'($urandom);
        endcase
    endfunction

    task automatic send_cells(input int unsigned count, input fill_t fill,
                              input value_t base, input int unsigned spread);
        repeat (count) send_cell(fill_value(fill, base, spread));
    endtask

    function automatic int unsigned clamp_side(logic [CFG_DATA_BITS-1:0] data);
        int unsigned raw;
        raw = data[GRID_SIDE_BITS-1:0];
        if (raw < MIN_SIDE) return MIN_SIDE;
        if (raw > MAX_SIDE) return MAX_SIDE;
        return raw;
    endfunction

    initial begin : stimulus
        int unsigned               random_start;
        int unsigned               side_now;
        int unsigned               spread;
        int unsigned               count;
        int unsigned               pick;
        logic [CFG_DATA_BITS-1:0]  side_data;
        logic [CFG_DATA_BITS-1:0]  thr_data;
        fill_t                     fill;
        value_t                    base;

        sweep_sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---------------------------------------------------
        // Side 0 clamps up to 3, so each sweep has exactly one interior cell.
        // Full-scale threshold: a full-scale ring around a zero center moves
        // by exactly the threshold, the widest neighbour sum there is.
        write_reg(CFG_GRID_SIDE, '0);
        write_reg(CFG_SETTLE_THRESHOLD, CFG_DATA_BITS'(VALUE_MAX));
        for (int i = 0; i < 9; i++) send_cell((i == 4) ? value_t'(0) : VALUE_MAX);
        // all-zero sweep: nothing moves, so the sweep reports settled
        send_cells(9, FILL_FLAT, '0, 0);
        // half a sweep, then a side write restarts at row 0, column 0
        send_cells(5, FILL_RANDOM, '0, 0);
        wait_idle();
        write_reg(CFG_GRID_SIDE, CFG_DATA_BITS'(MIN_SIDE));
        write_reg(CFG_SETTLE_THRESHOLD, CFG_DATA_BITS'(THRESHOLD_RESET));
        send_cells(MIN_SIDE * MIN_SIDE, FILL_RANDOM, '0, 0);

        // --- output hold-off: sender runs flat out while the sink stalls -----
        wait_idle();
        write_reg(CFG_GRID_SIDE, CFG_DATA_BITS'(12));
        tx_gap_max   = 0;
        rx_gap_max   = 0;
        hold_request = 1'b1;
        send_cells(3 * 12 * 12, FILL_RANDOM, '0, 0);
        phases++;
        side_now = 12;

        // --- random phases -----------------------------------------------------
        // Mostly whole sweeps of random content; a few threshold-only changes
        // that keep the current sweep going, and a few cut-off sweeps.
        random_start = cells_sent;
        while (cells_sent - random_start < RANDOM_CELLS) begin
            // sender waits here until every expected result has come
            wait_idle();
            phases++;
            tx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : IDLE_MAX;
            rx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : IDLE_MAX;

            fill   = fill_t'($urandom_range(0, 3));
            spread = $urandom_range(0, 1 << $urandom_range(0, 14));
            base   = value_t'($urandom_range(0, VALUE_MAX - spread));

            pick = $urandom_range(0, 7);
            if (pick == 0)      thr_data = '0;
            else if (pick == 1) thr_data = CFG_DATA_BITS'(VALUE_MAX);
            else if (pick == 2) thr_data = CFG_DATA_BITS'($urandom);
            else                thr_data = CFG_DATA_BITS'($urandom_range(0, 2 * spread + 1));

            if ($urandom_range(0, 9) < 2) begin
                // threshold only: the sweep in flight carries on
                write_reg(CFG_SETTLE_THRESHOLD, thr_data);
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    side_data = CFG_DATA_BITS'($urandom_range(0, MIN_SIDE - 1));
                else if (pick == 1)
                    side_data = (CFG_DATA_BITS'($urandom) & 24'hFFF800)
                              | CFG_DATA_BITS'($urandom_range(MIN_SIDE, 12));
                else if (pick < 4)
                    side_data = CFG_DATA_BITS'($urandom_range(13, 32));
                else
                    side_data = CFG_DATA_BITS'($urandom_range(MIN_SIDE, 12));
                side_now = clamp_side(side_data);
                write_reg(CFG_GRID_SIDE, side_data);
                write_reg(CFG_SETTLE_THRESHOLD, thr_data);
            end

            if ($urandom_range(0, 5) == 0)
                count = $urandom_range(1, 2 * side_now * side_now);
            else if (side_now > 12)
                count = side_now * side_now;
            else
                count = $urandom_range(1, 3) * side_now * side_now;
            send_cells(count, fill, base, spread);
        end

        // --- largest side, reached through an over-range write -----------------
        // 2047 clamps to 1024; a stretch of the first row runs at that side.
        wait_idle();
        phases++;
        tx_gap_max = 0;
        rx_gap_max = 0;
        write_reg(CFG_GRID_SIDE, CFG_DATA_BITS'(11'h7FF));
        write_reg(CFG_SETTLE_THRESHOLD, CFG_DATA_BITS'($urandom));
        send_cells(MAX_SIDE_CELLS, FILL_RANDOM, '0, 0);

        wait_idle();
        $display("Run covered %0d cells in %0d phases, %0d results checked, %0d sweep ends",
                 sweep_sb.cells_seen, phases, sweep_sb.results_seen, sweep_sb.sweep_ends);
        $display("(%0d settled), sides 3 to 32 incl. clamped writes, a partial row at 1024.",
                 sweep_sb.settled_sweeps);
        if (sweep_sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog: stops the run with an error long after the slowest correct run would end
    initial begin : watchdog
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
